### src/scaled_glyph_renderer_defines.svh
// ----------------------------------------------------------------------------
// Scaled glyph renderer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SCALED_GLYPH_RENDERER_DEFINES_SVH
`define SCALED_GLYPH_RENDERER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SGR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SGR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/sgr_pkg.sv
// ----------------------------------------------------------------------------
// Scaled glyph renderer package
// Widths, codes and the command and status types shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sgr_pkg;

    localparam int MAX_SCALE   = 8;
    localparam int GLYPH_COUNT = 128;
    localparam int GLYPH_W     = 5;
    localparam int GLYPH_H     = 7;
    localparam int ADVANCE     = 6;
    localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_H;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int MASK_W      = GLYPH_W * MAX_SCALE;
    localparam int SUB_W       = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

    localparam int KIND_W     = 2;
    localparam int CODE_W     = 8;
    localparam int ROW_W      = 3;
    localparam int POS_W      = 12;
    localparam int COLOR_W    = 32;
    localparam int ADDR_W     = 26;
    localparam int PX_W       = 13;
    localparam int PY_W       = 12;
    localparam int SCALE_W    = 4;
    localparam int DIM_W      = 13;
    localparam int PITCH_W    = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    localparam logic [KIND_W-1:0] KIND_LOAD     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DRAW_XY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DRAW_CUR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FB_PRESENT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE         = 3'd4;

    typedef struct packed {
        logic load;
        logic capture;
        logic setup;
        logic issue;
        logic flush;
    } sgr_cmd_t;

    typedef struct packed {
        logic adv;
        logic draw_ok;
        logic last_row;
        logic pend_valid;
    } sgr_status_t;

endpackage

`default_nettype wire

### src/sgr_ctrl.sv
// ----------------------------------------------------------------------------
// Scaled glyph renderer controller
// Sequences request intake, draw setup, the row sweep, drain and flush.
// ----------------------------------------------------------------------------
`default_nettype none

module sgr_ctrl
    import sgr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [KIND_W-1:0] kind,
    input  sgr_status_t       status,
    output sgr_cmd_t          cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ROWS,
        ST_DRAIN,
        ST_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   is_draw;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign is_draw  = (kind == KIND_DRAW_XY) || (kind == KIND_DRAW_CUR);

    always_comb
    begin
        cmd.load    = accept && (kind == KIND_LOAD);
        cmd.capture = accept && is_draw;
        cmd.setup   = (state_reg == ST_SETUP);
        cmd.issue   = (state_reg == ST_ROWS);
        cmd.flush   = (state_reg == ST_FLUSH);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_draw && status.draw_ok)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_ROWS;
            end
            ST_ROWS:
            begin
                if (status.adv && status.last_row)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.adv)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!status.pend_valid || status.adv)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### src/sgr_datapath.sv
// ----------------------------------------------------------------------------
// Scaled glyph renderer datapath
// Font store, configuration, cursor, row sweep, mask build and output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sgr_datapath
    import sgr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  sgr_cmd_t              cmd,
    output sgr_status_t           status,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [KIND_W-1:0]     kind,
    input  logic [CODE_W-1:0]     char_code,
    input  logic [ROW_W-1:0]      font_row,
    input  logic [GLYPH_W-1:0]    font_bits,
    input  logic [POS_W-1:0]      x_pos,
    input  logic [POS_W-1:0]      y_pos,
    input  logic [COLOR_W-1:0]    color,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ADDR_W-1:0]     row_address,
    output logic [PX_W-1:0]       pixel_x,
    output logic [PY_W-1:0]       pixel_y,
    output logic [MASK_W-1:0]     pixel_mask,
    output logic [COLOR_W-1:0]    color_res,
    output logic                  last
);

    logic [GLYPH_W-1:0] font_mem [STORE_DEPTH];

    logic                fb_present_reg;
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;
    logic [PITCH_W-1:0]  pitch_reg;
    logic [SCALE_W-1:0]  scale_reg;

    logic [PX_W-1:0]     cursor_x_reg;
    logic [PY_W-1:0]     cursor_y_reg;
    logic [PX_W-1:0]     x0_reg;
    logic [PY_W-1:0]     y0_reg;
    logic [COLOR_W-1:0]  color_reg;
    logic [CODE_W-1:0]   code_reg;
    logic [SCALE_W-1:0]  s_reg;
    logic [MASK_W-1:0]   span_reg [GLYPH_W];

    logic [ROW_W-1:0]    g_reg;
    logic [SUB_W-1:0]    k_reg;
    logic [PY_W:0]       ya_reg;
    logic [ADDR_W-1:0]   addra_reg;

    logic                bvalid_reg;
    logic                visb_reg;
    logic [GLYPH_W-1:0]  rd_reg;
    logic [PY_W-1:0]     yb_reg;
    logic [ADDR_W-1:0]   addrb_reg;

    logic                p_valid_reg;
    logic [ADDR_W-1:0]   p_addr_reg;
    logic [PY_W-1:0]     p_y_reg;
    logic [MASK_W-1:0]   p_mask_reg;

    logic                out_valid_reg;
    logic [ADDR_W-1:0]   o_addr_reg;
    logic [PX_W-1:0]     o_x_reg;
    logic [PY_W-1:0]     o_y_reg;
    logic [MASK_W-1:0]   o_mask_reg;
    logic [COLOR_W-1:0]  o_color_reg;
    logic                o_last_reg;

    logic [SCALE_W-1:0]  eff_scale;
    logic [PX_W-1:0]     start_x;
    logic [PX_W:0]       adv_sum;
    logic [PX_W-1:0]     cursor_x_next;
    logic [STORE_AW-1:0] wr_addr;
    logic [STORE_AW-1:0] rd_addr;
    logic [PX_W:0]       room;
    logic [MASK_W-1:0]   clip;
    logic [MASK_W-1:0]   ones;
    logic [ADDR_W-1:0]   base_addr;
    logic                adv;
    logic                last_row;
    logic                vis_a;
    logic [MASK_W-1:0]   cand_mask;
    logic                cand;
    logic                move_flush;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_present_reg <= 1'b0;
            width_reg      <= '0;
            height_reg     <= '0;
            pitch_reg      <= '0;
            scale_reg      <= SCALE_W'(1);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_FB_PRESENT:    fb_present_reg <= cfg_wdata[0];
                REG_SCREEN_WIDTH:  width_reg      <= cfg_wdata[DIM_W-1:0];
                REG_SCREEN_HEIGHT: height_reg     <= cfg_wdata[DIM_W-1:0];
                REG_ROW_PITCH:     pitch_reg      <= cfg_wdata[PITCH_W-1:0];
                REG_SCALE:         scale_reg      <= cfg_wdata[SCALE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign eff_scale = (scale_reg > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE) : scale_reg;

    assign status.draw_ok = fb_present_reg && (eff_scale != '0) &&
                            ({1'b0, char_code} < (CODE_W + 1)'(GLYPH_COUNT));

    // Cursor advance by six scaled columns, saturating at the top of the range.
    assign start_x = (kind == KIND_DRAW_XY) ? PX_W'(x_pos) : cursor_x_reg;
    assign adv_sum = {1'b0, start_x} + (PX_W + 1)'(eff_scale) * (PX_W + 1)'(ADVANCE);
    assign cursor_x_next = adv_sum[PX_W] ? {PX_W{1'b1}} : adv_sum[PX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
        end
        else if (cmd.capture)
        begin
            cursor_x_reg <= cursor_x_next;
            if (kind == KIND_DRAW_XY)
            begin
                cursor_y_reg <= y_pos;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x0_reg    <= start_x;
            y0_reg    <= (kind == KIND_DRAW_XY) ? y_pos : cursor_y_reg;
            color_reg <= color;
            code_reg  <= char_code;
            s_reg     <= eff_scale;
        end
    end

    // Font store: one write port for loads, one registered read port for rows.
    assign wr_addr = STORE_AW'(char_code) * STORE_AW'(GLYPH_H) + STORE_AW'(font_row);
    assign rd_addr = STORE_AW'(code_reg) * STORE_AW'(GLYPH_H) + STORE_AW'(g_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load && ({1'b0, char_code} < (CODE_W + 1)'(GLYPH_COUNT)) &&
            (font_row < ROW_W'(GLYPH_H)))
        begin
            font_mem[wr_addr] <= font_bits;
        end
        if (adv && cmd.issue)
        begin
            rd_reg <= font_mem[rd_addr];
        end
    end

    // Per-character setup: clipped column spans and the first row address.
    assign room = {1'b0, width_reg} - {1'b0, x0_reg};
    assign ones = (MASK_W'(1) << s_reg) - MASK_W'(1);
    assign base_addr = ADDR_W'(ADDR_W'(y0_reg) * ADDR_W'(pitch_reg)) + ADDR_W'(x0_reg);

    always_comb
    begin
        for (int c = 0; c < MASK_W; c++)
        begin
            clip[c] = !room[PX_W] && ((PX_W + 1)'(c) < room);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            for (int gc = 0; gc < GLYPH_W; gc++)
            begin
                span_reg[gc] <= (ones << (int'(s_reg) * gc)) & clip;
            end
        end
    end

    // Row sweep: glyph row, repeat index within the scale, screen row, address.
    assign adv      = !out_valid_reg || out_ready;
    assign last_row = (g_reg == ROW_W'(GLYPH_H - 1)) &&
                      (SCALE_W'(k_reg) == s_reg - SCALE_W'(1));
    assign vis_a    = !ya_reg[PY_W] && (ya_reg < height_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            g_reg     <= '0;
            k_reg     <= '0;
            ya_reg    <= {1'b0, y0_reg};
            addra_reg <= base_addr;
        end
        else if (adv && cmd.issue)
        begin
            if (SCALE_W'(k_reg) == s_reg - SCALE_W'(1))
            begin
                k_reg <= '0;
                g_reg <= g_reg + ROW_W'(1);
            end
            else
            begin
                k_reg <= k_reg + SUB_W'(1);
            end
            ya_reg    <= ya_reg + (PY_W + 1)'(1);
            addra_reg <= addra_reg + ADDR_W'(pitch_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && cmd.issue)
        begin
            visb_reg  <= vis_a;
            yb_reg    <= ya_reg[PY_W-1:0];
            addrb_reg <= addra_reg;
        end
    end

    // Row mask from the fetched glyph bits.
    always_comb
    begin
        cand_mask = '0;
        for (int gc = 0; gc < GLYPH_W; gc++)
        begin
            cand_mask = cand_mask | (span_reg[gc] & {MASK_W{rd_reg[GLYPH_W-1-gc]}});
        end
    end

    assign cand       = bvalid_reg && visb_reg && (cand_mask != '0);
    assign move_flush = cmd.flush && p_valid_reg;

    // A row result waits in the pending stage until the next one shows whether
    // it is the character's final row.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bvalid_reg    <= 1'b0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            bvalid_reg <= cmd.issue;
            if (cand)
            begin
                p_valid_reg   <= 1'b1;
                out_valid_reg <= p_valid_reg;
            end
            else if (move_flush)
            begin
                p_valid_reg   <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && ((cand && p_valid_reg) || move_flush))
        begin
            o_addr_reg  <= p_addr_reg;
            o_x_reg     <= x0_reg;
            o_y_reg     <= p_y_reg;
            o_mask_reg  <= p_mask_reg;
            o_color_reg <= color_reg;
            o_last_reg  <= !cand;
        end
        if (adv && cand)
        begin
            p_addr_reg <= addrb_reg;
            p_y_reg    <= yb_reg;
            p_mask_reg <= cand_mask;
        end
    end

    assign status.adv        = adv;
    assign status.last_row   = last_row;
    assign status.pend_valid = p_valid_reg;

    assign out_valid   = out_valid_reg;
    assign row_address = o_addr_reg;
    assign pixel_x     = o_x_reg;
    assign pixel_y     = o_y_reg;
    assign pixel_mask  = o_mask_reg;
    assign color_res   = o_color_reg;
    assign last        = o_last_reg;

endmodule

`default_nettype wire

### src/scaled_glyph_renderer.sv
// ----------------------------------------------------------------------------
// Scaled glyph renderer
// Turns 5x7 font characters, enlarged by an integer scale, into row writes.
// ----------------------------------------------------------------------------
// The input channel takes one request at a time: a font row load or a draw,
// either at an explicit position or at the kept cursor. The output channel
// gives one row write per visible, non-empty scaled row, with last set on
// the final row of a character. Configuration is written through a plain
// write port; the user is to write it only while the block is idle, which
// the block does not enforce. A font load leaves the block idle, as does a
// draw with the framebuffer off, scale zero or a code out of range. Any
// other draw is taken, then a setup state forms the first row address and
// the clipped column spans, the sweep gives one scaled row per cycle through
// the font store read port while the receiver does not stall, and the drain
// and flush states empty the row pipeline and the held result. A result
// passes from the read register through the pending stage to the output
// registers; it is held back until the next non-empty row or the end of the
// character shows whether it is the final one.
// Reset clears the configuration (scale to one), the cursor and all valid
// flags; the font store holds no defined contents until written. When the
// receiver stalls, the row sweep stops in place and resumes without loss.
// ----------------------------------------------------------------------------
`default_nettype none

module scaled_glyph_renderer
    import sgr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [KIND_W-1:0]     kind,
    input  logic [CODE_W-1:0]     char_code,
    input  logic [ROW_W-1:0]      font_row,
    input  logic [GLYPH_W-1:0]    font_bits,
    input  logic [POS_W-1:0]      x_pos,
    input  logic [POS_W-1:0]      y_pos,
    input  logic [COLOR_W-1:0]    color,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ADDR_W-1:0]     row_address,
    output logic [PX_W-1:0]       pixel_x,
    output logic [PY_W-1:0]       pixel_y,
    output logic [MASK_W-1:0]     pixel_mask,
    output logic [COLOR_W-1:0]    color_res,
    output logic                  last
);

    sgr_cmd_t    cmd;
    sgr_status_t status;

    sgr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .status   (status),
        .cmd      (cmd)
    );

    sgr_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .kind        (kind),
        .char_code   (char_code),
        .font_row    (font_row),
        .font_bits   (font_bits),
        .x_pos       (x_pos),
        .y_pos       (y_pos),
        .color       (color),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .row_address (row_address),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_mask  (pixel_mask),
        .color_res   (color_res),
        .last        (last)
    );

endmodule

`default_nettype wire

### src/sgr_checker.sv
// ----------------------------------------------------------------------------
// Scaled glyph renderer checker
// Port-level assertions on the renderer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "scaled_glyph_renderer_defines.svh"

module sgr_checker
    import sgr_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic [KIND_W-1:0]     kind,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [ADDR_W-1:0]     row_address,
    input logic [MASK_W-1:0]     pixel_mask,
    input logic                  last
);

    // A stalled result keeps its place and contents.
    `SGR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pixel_mask) && $stable(row_address) && $stable(last), "stalled result changed")

    // Empty rows are never reported.
    `SGR_ASSERT_SAME(a_mask_nonzero, out_valid, pixel_mask != '0, "result with empty mask")

    // While a new request can be taken, any waiting result closes its character.
    `SGR_ASSERT_SAME(a_idle_last, in_ready && out_valid, last, "idle with unfinished character")

    // A font load never creates a result.
    `SGR_ASSERT_NEXT(a_load_quiet, in_valid && in_ready && (kind == KIND_LOAD) && !out_valid, !out_valid, "result after font load")

endmodule

bind scaled_glyph_renderer sgr_checker u_sgr_checker (.*);

`default_nettype wire

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Scaled glyph renderer testbench
// Loads font glyphs, draws characters under a range of screen, pitch and
// scale settings, and checks every row write against a scoreboard that
// predicts the clipped, scaled rows and the cursor movement on its own.
// ----------------------------------------------------------------------------
module testbench;
    import sgr_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int unsigned X_LIMIT       = 8191;
    localparam int unsigned Y_LIMIT       = 4095;
    localparam int          SETTLE_CYCLES = GLYPH_H * MAX_SCALE + 16;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          WATCHDOG      = 1_000_000;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [CODE_W-1:0]  code;
        logic [ROW_W-1:0]   row;
        logic [GLYPH_W-1:0] bits;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [COLOR_W-1:0] color;
    } glyph_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        logic [PX_W-1:0]    x;
        logic [PY_W-1:0]    y;
        logic [MASK_W-1:0]  mask;
        logic [COLOR_W-1:0] color;
        logic               last;
    } row_write_t;

    typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_TOGGLE} ready_pattern_t;

    class glyph_scoreboard;
        logic [GLYPH_W-1:0] glyph_rows [STORE_DEPTH];
        int unsigned        cur_x;
        int unsigned        cur_y;
        bit                 fb_on;
        int unsigned        width_px;
        int unsigned        height_px;
        int unsigned        pitch;
        int unsigned        scale_reg;
        row_write_t         expected_rows [$];
        int unsigned        errors;

        function new();
            foreach (glyph_rows[i])
                glyph_rows[i] = '0;
            cur_x     = 0;
            cur_y     = 0;
            fb_on     = 1'b0;
            width_px  = 0;
            height_px = 0;
            pitch     = 0;
            scale_reg = 1;
            errors    = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_FB_PRESENT:    fb_on = data[0];
                REG_SCREEN_WIDTH:  width_px = data[DIM_W-1:0];
                REG_SCREEN_HEIGHT: height_px = data[DIM_W-1:0];
                REG_ROW_PITCH:     pitch = data[PITCH_W-1:0];
                REG_SCALE:         scale_reg = data[SCALE_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned effective_scale();
            return (scale_reg > MAX_SCALE) ? MAX_SCALE : scale_reg;
        endfunction

        function int unsigned advance(int unsigned x);
            int unsigned n;
            n = x + ADVANCE * effective_scale();
            return (n > X_LIMIT) ? X_LIMIT : n;
        endfunction

        function void render(int unsigned code, int unsigned x0, int unsigned y0,
                             logic [COLOR_W-1:0] col);
            int unsigned s;
            int unsigned y;
            int unsigned full_addr;
            logic [GLYPH_W-1:0] bits;
            logic [MASK_W-1:0] mask;
            row_write_t held;
            bit have_held;
            s = effective_scale();
            have_held = 1'b0;
            if (!fb_on || s == 0 || code >= GLYPH_COUNT)
                return;
            for (int unsigned r = 0; r < GLYPH_H * s; r++) begin
                y = y0 + r;
                if (y >= height_px || y > Y_LIMIT)
                    continue;
                bits = glyph_rows[code * GLYPH_H + r / s];
                mask = '0;
                for (int unsigned c = 0; c < GLYPH_W * s; c++)
                    if (bits[GLYPH_W - 1 - c / s] && x0 + c < width_px)
                        mask[c] = 1'b1;
                if (mask == '0)
                    continue;
                if (have_held)
                    expected_rows.push_back(held);
                full_addr = y * pitch + x0;
                held = {full_addr[ADDR_W-1:0], x0[PX_W-1:0], y[PY_W-1:0], mask, col, 1'b0};
                have_held = 1'b1;
            end
            if (have_held) begin
                held.last = 1'b1;
                expected_rows.push_back(held);
            end
        endfunction

        function void note_request(glyph_req_t req);
            case (req.kind)
                KIND_LOAD:
                    if (req.code < GLYPH_COUNT && req.row < GLYPH_H)
                        glyph_rows[req.code * GLYPH_H + req.row] = req.bits;
                KIND_DRAW_XY: begin
                    render(req.code, req.x, req.y, req.color);
                    cur_x = advance(req.x);
                    cur_y = req.y;
                end
                KIND_DRAW_CUR: begin
                    render(req.code, cur_x, cur_y, req.color);
                    cur_x = advance(cur_x);
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_row(row_write_t got);
            row_write_t want;
            if (expected_rows.size() == 0) begin
                errors++;
                $display("%0t unexpected row write: address %0h, y %0d, mask %0h",
                         $time, got.address, got.y, got.mask);
                return;
            end
            want = expected_rows.pop_front();
            compare_field("row_address", want.address, got.address);
            compare_field("pixel_x", want.x, got.x);
            compare_field("pixel_y", want.y, got.y);
            compare_field("pixel_mask", want.mask, got.mask);
            compare_field("color_res", want.color, got.color);
            compare_field("last", want.last, got.last);
        endfunction

        function int unsigned pending();
            return expected_rows.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n       = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic [KIND_W-1:0]     kind        = '0;
    logic [CODE_W-1:0]     char_code   = '0;
    logic [ROW_W-1:0]      font_row    = '0;
    logic [GLYPH_W-1:0]    font_bits   = '0;
    logic [POS_W-1:0]      x_pos       = '0;
    logic [POS_W-1:0]      y_pos       = '0;
    logic [COLOR_W-1:0]    color       = '0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic [ADDR_W-1:0]     row_address;
    logic [PX_W-1:0]       pixel_x;
    logic [PY_W-1:0]       pixel_y;
    logic [MASK_W-1:0]     pixel_mask;
    logic [COLOR_W-1:0]    color_res;
    logic                  last;

    glyph_scoreboard sb;
    int unsigned     burst_left = 0;
    int unsigned     holds_requested = 0;
    bit [GLYPH_H-1:0] rows_loaded [GLYPH_COUNT];
    bit              glyph_ready [GLYPH_COUNT];
    int unsigned     ready_codes [$];

    scaled_glyph_renderer i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin : watchdog
        #(WATCHDOG);
        $display("status: fail");
        $finish;
    end

    always @(posedge clk)
    begin : monitor
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_request({kind, char_code, font_row, font_bits, x_pos, y_pos, color});
            if (out_valid && out_ready)
                sb.check_row({row_address, pixel_x, pixel_y, pixel_mask, color_res, last});
        end
    end

    initial
    begin : receiver
        int unsigned    holds_served;
        int unsigned    hold_left;
        int unsigned    span_left;
        ready_pattern_t pattern;
        holds_served = 0;
        hold_left    = 0;
        span_left    = 0;
        pattern      = READY_ALWAYS;
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (holds_requested != holds_served)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                if (span_left == 0)
                begin
                    pattern   = ready_pattern_t'($urandom_range(0, 3));
                    span_left = $urandom_range(5, 60);
                end
                span_left--;
                case (pattern)
                    READY_ALWAYS: out_ready <= 1'b1;
                    READY_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
                    READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                    default:      out_ready <= ~out_ready;
                endcase
            end
        end
    end

    function automatic glyph_req_t random_fields();
        glyph_req_t req;
        req.kind  = KIND_W'($urandom_range(0, 3));
        req.code  = CODE_W'($urandom_range(0, 255));
        req.row   = ROW_W'($urandom_range(0, 7));
        req.bits  = GLYPH_W'($urandom_range(0, 31));
        req.x     = POS_W'($urandom_range(0, 4095));
        req.y     = POS_W'($urandom_range(0, 4095));
        req.color = $urandom();
        return req;
    endfunction

    function automatic glyph_req_t font_load(int unsigned code, int unsigned row,
                                             int unsigned bits);
        glyph_req_t req;
        req      = random_fields();
        req.kind = KIND_LOAD;
        req.code = CODE_W'(code);
        req.row  = ROW_W'(row);
        req.bits = GLYPH_W'(bits);
        return req;
    endfunction

    function automatic glyph_req_t draw_req(logic [KIND_W-1:0] draw_kind, int unsigned code,
                                            int unsigned x, int unsigned y);
        glyph_req_t req;
        req      = random_fields();
        req.kind = draw_kind;
        req.code = CODE_W'(code);
        req.x    = POS_W'(x);
        req.y    = POS_W'(y);
        return req;
    endfunction

    function automatic int unsigned pick_code();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(GLYPH_COUNT, 255);
        return ready_codes[$urandom_range(0, ready_codes.size() - 1)];
    endfunction

    task automatic offer(input glyph_req_t req);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        if (req.kind == KIND_LOAD && req.code < GLYPH_COUNT && req.row < GLYPH_H)
        begin
            rows_loaded[req.code][req.row] = 1'b1;
            if (&rows_loaded[req.code] && !glyph_ready[req.code])
            begin
                glyph_ready[req.code] = 1'b1;
                ready_codes.push_back(req.code);
            end
        end
        in_valid  <= 1'b1;
        kind      <= req.kind;
        char_code <= req.code;
        font_row  <= req.row;
        font_bits <= req.bits;
        x_pos     <= req.x;
        y_pos     <= req.y;
        color     <= req.color;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic load_glyph(input int unsigned code, input logic [GLYPH_H*GLYPH_W-1:0] art);
        for (int unsigned r = 0; r < GLYPH_H; r++)
            offer(font_load(code, r, art[(GLYPH_H - 1 - r) * GLYPH_W +: GLYPH_W]));
    endtask

    // A draw that produces no row writes can still be in progress when the
    // last expected row arrives, so allow a full character time afterwards.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input int unsigned fb, input int unsigned wd, input int unsigned ht,
                             input int unsigned rp, input int unsigned scl);
        logic [CFG_IDX_W-1:0]  index [5];
        logic [CFG_DATA_W-1:0] value [5];
        index = '{REG_FB_PRESENT, REG_SCREEN_WIDTH, REG_SCREEN_HEIGHT, REG_ROW_PITCH, REG_SCALE};
        value = '{CFG_DATA_W'(fb), CFG_DATA_W'(wd), CFG_DATA_W'(ht), CFG_DATA_W'(rp),
                  CFG_DATA_W'(scl)};
        for (int i = 0; i < 5; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= index[i];
            cfg_wdata <= value[i];
            sb.set_register(index[i], value[i]);
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned sent;
        int unsigned pick;
        int unsigned code;
        glyph_req_t  req;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 18)
            begin
                code = $urandom_range(0, GLYPH_COUNT - 1);
                for (int unsigned r = 0; r < GLYPH_H; r++)
                    offer(font_load(code, r, $urandom_range(0, 31)));
                sent += GLYPH_H;
            end
            else if (pick < 26)
            begin
                offer(font_load($urandom_range(0, 255), $urandom_range(0, 7),
                                $urandom_range(0, 31)));
                sent++;
            end
            else if (pick < 30)
            begin
                req      = random_fields();
                req.kind = KIND_UNUSED;
                offer(req);
            end
            else
            begin
                req = draw_req(($urandom_range(0, 1) == 1) ? KIND_DRAW_XY : KIND_DRAW_CUR,
                               pick_code(), $urandom_range(0, 4095), $urandom_range(0, 4095));
                if ($urandom_range(0, 5) == 0)
                begin
                    req.x = POS_W'($urandom_range(4064, 4095));
                    req.y = POS_W'($urandom_range(4064, 4095));
                end
                else if ($urandom_range(0, 2) == 0)
                begin
                    req.x = POS_W'($urandom_range(0, 63));
                    req.y = POS_W'($urandom_range(0, 63));
                end
                offer(req);
                sent++;
            end
        end
    endtask

    // Starts at the right edge and keeps drawing at the cursor until the
    // cursor has saturated; the start row makes the bottom rows fall off.
    task automatic run_text_line(input int unsigned count);
        offer(draw_req(KIND_DRAW_XY, pick_code(), 4095, 4080));
        repeat (count)
            offer(draw_req(KIND_DRAW_CUR, pick_code(), 0, 0));
    endtask

    initial
    begin : stimulus
        glyph_req_t junk;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_glyph(0, {5'b01110, 5'b10001, 5'b10001, 5'b11111, 5'b10001, 5'b10001, 5'b00000});
        load_glyph(GLYPH_COUNT - 1,
                   {5'b11111, 5'b10101, 5'b01010, 5'b00100, 5'b01010, 5'b10101, 5'b11111});
        offer(font_load(GLYPH_COUNT, 0, 31));
        offer(font_load(5, 7, 31));
        junk      = '1;
        junk.kind = KIND_UNUSED;
        offer(junk);
        offer(draw_req(KIND_DRAW_XY, 0, 10, 20));
        settle();

        configure(1, 100, 60, 640, 2);
        offer(draw_req(KIND_DRAW_CUR, GLYPH_COUNT - 1, 0, 0));
        offer(draw_req(KIND_DRAW_XY, 0, 0, 0));
        offer(draw_req(KIND_DRAW_XY, GLYPH_COUNT - 1, 95, 55));
        offer(draw_req(KIND_DRAW_CUR, GLYPH_COUNT, 0, 0));
        offer(draw_req(KIND_DRAW_CUR, 255, 0, 0));
        offer(draw_req(KIND_DRAW_XY, 0, 4095, 4095));
        settle();

        configure(1, 4096, 4096, 4096, 1);
        run_random(12);
        settle();
        configure(1, 37, 4096, 16383, 8);
        holds_requested++;
        run_random(14);
        settle();
        configure(0, 4096, 4096, 640, 3);
        run_random(6);
        settle();
        configure(1, 4096, 4096, 1024, 0);
        run_random(4);
        settle();
        configure(1, 0, 8191, 0, 5);
        run_random(4);
        settle();
        configure(1, 8191, 0, 1, 7);
        run_random(4);
        settle();
        configure(1, 300, 200, 800, 4);
        run_random(10);
        settle();
        configure(1, 8191, 8191, 16383, 15);
        run_text_line(88);
        settle();

        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
